// ----- rtl/core/modular_exponentiation_top_defines.svh -----
// Assertion macros shared by the modular exponentiation RTL.
// Define ASSERT_OFF to compile the checks away.
`ifndef MODULAR_EXPONENTIATION_TOP_DEFINES_SVH
`define MODULAR_EXPONENTIATION_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/modexp_pkg.sv -----
package modexp_pkg;

  // Width of the base and result words and of the configuration data.
  localparam int DATA_WIDTH = 32;

  // Configuration register indexes.
  localparam int CFG_IDX_WIDTH = 1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_EXPONENT = 1'b0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_MODULUS  = 1'b1;

  // The serial multiplier always scans a full data word of its second operand.
  localparam int OPB_WIDTH = DATA_WIDTH;
  localparam int CNT_WIDTH = $clog2(OPB_WIDTH + 1);

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_DISPATCH,
    ST_MUL_ACC,
    ST_SQUARE,
    ST_FINISH
  } state_e;

  // Status of the serial modular multiplier.
  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

// ----- rtl/core/modexp_in_if.sv -----
interface modexp_in_if import modexp_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] base_value;

  modport source (output valid, output base_value, input ready);
  modport sink (input valid, input base_value, output ready);
endinterface

// ----- rtl/core/modexp_out_if.sv -----
interface modexp_out_if import modexp_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] power_result;

  modport source (output valid, output power_result, input ready);
  modport sink (input valid, input power_result, output ready);
endinterface

// ----- rtl/core/modexp_mul.sv -----
module modexp_mul import modexp_pkg::*; #(
  parameter int MOD_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [MOD_WIDTH-1:0] op_a_i,
  input  logic [OPB_WIDTH-1:0] op_b_i,
  input  logic [MOD_WIDTH-1:0] mod_i,
  output mul_stat_t            stat_o,
  output logic [MOD_WIDTH-1:0] res_o
);

  // The partial remainder doubled plus one addend stays below three times the modulus.
  localparam int TW = MOD_WIDTH + 2;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [MOD_WIDTH-1:0] a_q;
  logic [OPB_WIDTH-1:0] b_q;
  logic [MOD_WIDTH-1:0] r_q;
  logic [TW-1:0]        sum;
  logic [TW-1:0]        mod1;
  logic [TW-1:0]        mod2;
  logic [TW-1:0]        red;

  // One bit of the second operand per cycle, most significant first:
  // r = (2r + bit * a) mod m, with at most two subtractions of m.
  always_comb begin
    mod1 = TW'(mod_i);
    mod2 = TW'({mod_i, 1'b0});
    sum  = TW'({r_q, 1'b0}) + (b_q[OPB_WIDTH-1] ? TW'(a_q) : '0);
    if (sum >= mod2) begin
      red = sum - mod2;
    end else if (sum >= mod1) begin
      red = sum - mod1;
    end else begin
      red = sum;
    end
  end

  // Iteration control.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_WIDTH'(OPB_WIDTH);
    end else if (busy_q) begin
      cnt_d = cnt_q - CNT_WIDTH'(1);
      if (cnt_q == CNT_WIDTH'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand shift register and partial remainder.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= op_a_i;
      b_q <= op_b_i;
      r_q <= '0;
    end else if (busy_q) begin
      b_q <= {b_q[OPB_WIDTH-2:0], 1'b0};
      r_q <= red[MOD_WIDTH-1:0];
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign res_o       = r_q;

endmodule

// ----- rtl/core/modular_exponentiation_top.sv -----
// Modular exponentiation: each item on in_i carries one base word, and the
// matching item on out_o carries base ^ exponent mod modulus.
// The exponent and modulus are set through the write port (index 0 is the
// exponent, index 1 the modulus); the user must write them only while the
// block is idle, which the block itself does not enforce. Both reset to 1.
// A zero modulus gives 0, and a zero exponent gives 1 for any nonzero modulus.
// One bit-serial modular multiplier does all the work, one operand bit per
// cycle. The base is first reduced; then for each exponent bit up to the
// highest set one there is a dispatch step, a product into the result when
// the bit is set, and a squaring of the base unless no higher bit remains.
// One item is worked on at a time; the next is taken once the result has
// entered the output register.
// The result moves into an output register, after which in_i is ready for
// the next item even when the receiver stalls; a further result then waits
// until the output register is taken.
// Reset clears the sequencer and the output valid and sets the configuration to 1.
`include "modular_exponentiation_top_defines.svh"

module modular_exponentiation_top import modexp_pkg::*; #(
  parameter int MOD_WIDTH = 32,
  parameter int EXP_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  modexp_in_if.sink                in_i,
  modexp_out_if.source             out_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [DATA_WIDTH-1:0]    cfg_wdata_i
);

  // The exponent register is at most 32 bits wide, so wider exponents add only zeros.
  localparam int ExpBits = (EXP_WIDTH < DATA_WIDTH) ? EXP_WIDTH : DATA_WIDTH;

  state_e                 state_q, state_d;
  logic [ExpBits-1:0]     exponent_q;
  logic [MOD_WIDTH-1:0]   modulus_q;
  logic [ExpBits-1:0]     exp_q, exp_d;
  logic [MOD_WIDTH-1:0]   base_q, base_d;
  logic [MOD_WIDTH-1:0]   acc_q, acc_d;
  logic                   out_valid_q, out_valid_d;
  logic [DATA_WIDTH-1:0]  out_data_q;
  logic                   out_load;
  logic                   in_fire;
  logic                   mul_start;
  logic [MOD_WIDTH-1:0]   mul_a;
  logic [OPB_WIDTH-1:0]   mul_b;
  logic [MOD_WIDTH-1:0]   mul_res;
  mul_stat_t              mul_stat;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exponent_q <= ExpBits'(1);
      modulus_q  <= MOD_WIDTH'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_EXPONENT: exponent_q <= cfg_wdata_i[ExpBits-1:0];
        REG_MODULUS:  modulus_q  <= cfg_wdata_i[MOD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  modexp_mul #(
    .MOD_WIDTH(MOD_WIDTH)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .op_a_i  (mul_a),
    .op_b_i  (mul_b),
    .mod_i   (modulus_q),
    .stat_o  (mul_stat),
    .res_o   (mul_res)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  // Sequencer: base reduction, then square-and-multiply from the low bit up.
  always_comb begin
    state_d   = state_q;
    exp_d     = exp_q;
    base_d    = base_q;
    acc_d     = acc_q;
    mul_start = 1'b0;
    mul_a     = base_q;
    mul_b     = OPB_WIDTH'(base_q);
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        mul_a = MOD_WIDTH'(1);
        mul_b = in_i.base_value;
        if (in_fire) begin
          exp_d = exponent_q;
          if (modulus_q == '0) begin
            acc_d   = '0;
            state_d = ST_FINISH;
          end else if (exponent_q == '0) begin
            acc_d   = MOD_WIDTH'(1);
            state_d = ST_FINISH;
          end else begin
            acc_d     = MOD_WIDTH'(1);
            mul_start = 1'b1;
            state_d   = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (mul_stat.done) begin
          base_d  = mul_res;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        mul_start = 1'b1;
        if (exp_q[0]) begin
          mul_a   = acc_q;
          state_d = ST_MUL_ACC;
        end else begin
          state_d = ST_SQUARE;
        end
      end
      ST_MUL_ACC: begin
        if (mul_stat.done) begin
          acc_d = mul_res;
          if (exp_q[ExpBits-1:1] == '0) begin
            state_d = ST_FINISH;
          end else begin
            mul_start = 1'b1;
            state_d   = ST_SQUARE;
          end
        end
      end
      ST_SQUARE: begin
        if (mul_stat.done) begin
          base_d  = mul_res;
          exp_d   = exp_q >> 1;
          state_d = ST_DISPATCH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk_i) begin
    exp_q  <= exp_d;
    base_q <= base_d;
    acc_q  <= acc_d;
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= DATA_WIDTH'(acc_q);
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.power_result = out_data_q;

  // The multiplier is only started when it is free.
  `ASSERT_IMPLY(a_mul_start_free, clk_i, rst_ni, mul_start, !mul_stat.busy)

  // A product only completes while the sequencer is waiting for one.
  `ASSERT_IMPLY(a_mul_done_expected, clk_i, rst_ni, mul_stat.done, (state_q == ST_REDUCE) || (state_q == ST_MUL_ACC) || (state_q == ST_SQUARE))

  // A finished result is reduced whenever the modulus is above one.
  `ASSERT_IMPLY(a_result_reduced, clk_i, rst_ni, (state_q == ST_FINISH) && (modulus_q > MOD_WIDTH'(1)), acc_q < modulus_q)

  // An accepted item always starts work.
  `ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni, in_fire, state_q != ST_IDLE)

endmodule
